>>> design/svd_pkg.sv
// Shared types, constants and build-time tables for the sine voice with tail decay.
`default_nettype none
package svd_pkg;

  // Build-time audio settings.
  localparam int unsigned SAMPLE_RATE    = 48000;
  localparam int unsigned SINE_ADDR_BITS = 10;
  localparam int unsigned QUARTER_BITS   = SINE_ADDR_BITS - 2;
  localparam int unsigned QUARTER_SIZE   = 1 << QUARTER_BITS;
  localparam int unsigned QIDX_W         = QUARTER_BITS + 1;
  localparam int unsigned NOTE_COUNT     = 128;

  // Phase step divisor (SAMPLE_RATE in Q.4) and its rounding half.
  localparam logic [63:0] STEP_DENOM = 64'(SAMPLE_RATE) << 4;
  localparam logic [63:0] STEP_HALF  = STEP_DENOM / 64'd2;

  // Configuration port.
  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_ADDR_FREQ_SCALE = 2'd0;
  localparam logic [15:0]        FREQ_SCALE_RESET    = 16'd4096;

  // Request codes.
  localparam logic [1:0] REQ_TICK     = 2'd0;
  localparam logic [1:0] REQ_NOTE_ON  = 2'd1;
  localparam logic [1:0] REQ_NOTE_OFF = 2'd2;
  localparam logic [1:0] REQ_UNUSED   = 2'd3;

  // Tail arithmetic: 1.0 in Q1.16, stop threshold (t * 200 <= 1.0), and the
  // reciprocal that replaces the divide by 100 for values below 2^23.
  localparam logic [16:0] TAIL_ONE      = 17'd65536;
  localparam logic [16:0] TAIL_STOP_MAX = 17'(65536 / 200);
  localparam logic [23:0] DIV100_MUL    = 24'd10737419;

  // Fixed-point helpers for the sine series.
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [31:0] phase_t;
  typedef logic [12:0] amp_t;
  typedef logic [16:0] tail_t;
  typedef logic [14:0] mag_t;

  // One voice state record as held in the state memory.
  typedef struct packed {
    phase_t phase;
    phase_t step;
    amp_t   amp;
    tail_t  tail;
  } voice_t;

  localparam int unsigned VOICE_W     = $bits(voice_t);
  localparam int unsigned VOICE_DEPTH = 1;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_MUL1 = 5'b00100,
    ST_MUL2 = 5'b01000,
    ST_OUT  = 5'b10000
  } seq_state_e;

  typedef mag_t         qsine_tab_t [QUARTER_SIZE+1];
  typedef logic [31:0]  step_tab_t  [NOTE_COUNT];
  typedef amp_t         amp_tab_t   [NOTE_COUNT];

  localparam logic [31:0] SEMITONE_Q30 [12] = '{
    32'd1073741824, 32'd1137589835, 32'd1205234447, 32'd1276901417,
    32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608794974,
    32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652
  };

  // Quarter-wave sine magnitude by a 9th-order series in Q30.
  function automatic mag_t quarter_sine(input int unsigned j);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    x  = (HALF_PI_Q30 * 64'(j)) >> QUARTER_BITS;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    v  = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

  function automatic qsine_tab_t build_qsine_tab();
    qsine_tab_t tab;
    for (int unsigned j = 0; j <= QUARTER_SIZE; j++) begin
      tab[j] = quarter_sine(j);
    end
    return tab;
  endfunction

  // Per-note phase step: round(f * 2^32 / SAMPLE_RATE).
  function automatic step_tab_t build_step_tab();
    step_tab_t   tab;
    int unsigned d;
    int unsigned octave;
    logic [63:0] numer;
    for (int unsigned n = 0; n < NOTE_COUNT; n++) begin
      d      = n + 51;
      octave = d / 12;
      numer  = (64'd440 * 64'(SEMITONE_Q30[d % 12])) << (octave - 4);
      numer  = (numer + STEP_HALF) / STEP_DENOM;
      tab[n] = numer[31:0];
    end
    return tab;
  endfunction

  // Level from velocity: round(4915.2 * v / 127).
  function automatic amp_tab_t build_amp_tab();
    amp_tab_t    tab;
    logic [31:0] a;
    for (int unsigned v = 0; v < NOTE_COUNT; v++) begin
      a      = (32'd24576 * 32'(v) + 32'd317) / 32'd635;
      tab[v] = a[12:0];
    end
    return tab;
  endfunction

  localparam qsine_tab_t QSINE_TAB     = build_qsine_tab();
  localparam step_tab_t  NOTE_STEP_TAB = build_step_tab();
  localparam amp_tab_t   AMP_TAB       = build_amp_tab();

endpackage
`default_nettype wire

>>> design/svd_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module svd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] rdata_q;

  if (DEPTH == 1) begin : g_single
    logic [WIDTH-1:0] word_q;

    // A single word: the address only qualifies the access.
    always_ff @(posedge clk_i) begin
      if (we_i && (waddr_i == '0)) begin
        word_q <= wdata_i;
      end
      if (re_i && (raddr_i == '0)) begin
        rdata_q <= word_q;
      end
    end
  end else begin : g_array
    logic [WIDTH-1:0] mem_q [DEPTH];

    always_ff @(posedge clk_i) begin
      if (we_i) begin
        mem_q[waddr_i] <= wdata_i;
      end
      if (re_i) begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> design/svd_cfg.sv
// APB-style configuration register block holding the pitch multiplier.
`default_nettype none
module svd_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [svd_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [svd_pkg::PDATA_W-1:0]     pwdata,
  output logic      [svd_pkg::PDATA_W-1:0]     prdata,
  output logic                                 pready,
  output logic      [15:0]                     freq_scale_o
);
  import svd_pkg::*;

  logic [15:0] freq_scale_q;
  logic        wr_hit;

  // A write completes in the access phase; the port never waits.
  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && pready && (paddr == REG_ADDR_FREQ_SCALE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_scale_q <= FREQ_SCALE_RESET;
    end else if (wr_hit) begin
      freq_scale_q <= pwdata[15:0];
    end
  end

  // Read back the register; unmapped addresses read as zero.
  always_comb begin
    prdata = '0;
    if (paddr == REG_ADDR_FREQ_SCALE) begin
      prdata = {{(PDATA_W - 16){1'b0}}, freq_scale_q};
    end
  end

  assign freq_scale_o = freq_scale_q;

endmodule
`default_nettype wire

>>> design/svd_core.sv
// Voice sequencer: reads the voice state, computes the sample and writes the state back.
`default_nettype none
module svd_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [15:0]          freq_scale_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           req_type_i,
  input  wire logic [6:0]           note_i,
  input  wire logic [6:0]           velocity_i,
  input  wire logic                 allow_tail_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [15:0]        sample_o,
  output logic                      active_o,
  output logic                      ram_we_o,
  output logic                      ram_re_o,
  output svd_pkg::voice_t           ram_wdata_o,
  input  svd_pkg::voice_t           ram_rdata_i
);
  import svd_pkg::*;

  seq_state_e state_q, state_d;

  // Transaction fields captured at acceptance.
  logic [1:0]  req_q;
  logic        allow_q;
  logic [31:0] tab_step_q;
  amp_t        amp_new_q;

  // Working registers of a tick.
  voice_t      cur_q;
  mag_t        mag_q;
  logic        neg_q;
  logic [22:0] x_q;
  amp_t        m1_q;
  tail_t       qdiv_q;

  // Finished result and output register.
  logic [15:0] res_sample_q, res_sample_d;
  logic        res_active_q, res_active_d;
  logic        res_load;
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_sample_q;
  logic        out_active_q;
  logic        out_load;

  logic        vs_valid_q;
  logic        in_accept;
  voice_t      rd_voice;
  voice_t      wr_voice;
  logic        wr_en;

  logic [SINE_ADDR_BITS-1:0] sine_idx;
  logic [1:0]                sine_quad;
  logic [QUARTER_BITS-1:0]   sine_j;
  logic [QIDX_W-1:0]         sine_jj;
  mag_t                      sine_mag;
  logic [47:0]               step_prod;
  logic [23:0]               x_full;
  logic [27:0]               amp_prod;
  logic [46:0]               div_prod;
  logic [29:0]               tail_prod;
  amp_t                      m2;
  logic [15:0]               tick_sample;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  // The state word is zero until the first write after reset.
  assign rd_voice = vs_valid_q ? ram_rdata_i : '0;

  // Quarter-wave sine lookup from the top phase bits.
  assign sine_idx  = rd_voice.phase[31 -: SINE_ADDR_BITS];
  assign sine_quad = sine_idx[SINE_ADDR_BITS-1 -: 2];
  assign sine_j    = sine_idx[QUARTER_BITS-1:0];
  assign sine_jj   = sine_quad[0] ? (QIDX_W'(QUARTER_SIZE) - {1'b0, sine_j})
                                  : {1'b0, sine_j};
  assign sine_mag  = QSINE_TAB[sine_jj];

  // Note-on phase step, scaled by the Q4.12 pitch multiplier.
  assign step_prod = 48'(tab_step_q) * 48'(freq_scale_i) + 48'd2048;

  // Tail decay numerator, then divide by 100 through the reciprocal.
  assign x_full   = 24'(rd_voice.tail) * 24'd99 + 24'd50;
  assign div_prod = 47'(x_q) * 47'(DIV100_MUL);

  // Level and tail products.
  assign amp_prod    = 28'(mag_q) * 28'(cur_q.amp) + 28'd16384;
  assign tail_prod   = 30'(m1_q) * 30'(cur_q.tail) + 30'd32768;
  assign m2          = (cur_q.tail != '0) ? tail_prod[28:16] : m1_q;
  assign tick_sample = neg_q ? (16'd0 - {3'b000, m2}) : {3'b000, m2};

  // Sequencer and state write-back.
  always_comb begin
    state_d      = state_q;
    wr_en        = 1'b0;
    wr_voice     = rd_voice;
    res_load     = 1'b0;
    res_sample_d = tick_sample;
    res_active_d = 1'b1;
    out_load     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && (req_type_i != REQ_UNUSED)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        case (req_q)
          REQ_NOTE_ON: begin
            wr_en          = 1'b1;
            wr_voice.phase = '0;
            wr_voice.step  = step_prod[43:12];
            wr_voice.amp   = amp_new_q;
            wr_voice.tail  = '0;
            state_d        = ST_IDLE;
          end
          REQ_NOTE_OFF: begin
            wr_en = 1'b1;
            if (allow_q) begin
              if (rd_voice.tail == '0) begin
                wr_voice.tail = TAIL_ONE;
              end
            end else begin
              wr_voice.step = '0;
              wr_voice.tail = '0;
            end
            state_d = ST_IDLE;
          end
          REQ_TICK: begin
            if (rd_voice.step == '0) begin
              res_load     = 1'b1;
              res_sample_d = '0;
              res_active_d = 1'b0;
              state_d      = ST_OUT;
            end else begin
              state_d = ST_MUL1;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_MUL1: begin
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        res_load       = 1'b1;
        wr_en          = 1'b1;
        wr_voice       = cur_q;
        wr_voice.phase = cur_q.phase + cur_q.step;
        if (cur_q.tail != '0) begin
          if (qdiv_q <= TAIL_STOP_MAX) begin
            wr_voice.step = '0;
            wr_voice.tail = '0;
          end else begin
            wr_voice.tail = qdiv_q;
          end
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: a loaded result stays until the transaction completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      vs_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (wr_en) begin
        vs_valid_q <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q      <= req_type_i;
      allow_q    <= allow_tail_i;
      tab_step_q <= NOTE_STEP_TAB[note_i];
      amp_new_q  <= AMP_TAB[velocity_i];
    end
    if (state_q == ST_READ) begin
      cur_q <= rd_voice;
      mag_q <= sine_mag;
      neg_q <= sine_quad[1];
      x_q   <= x_full[22:0];
    end
    if (state_q == ST_MUL1) begin
      m1_q   <= amp_prod[27:15];
      qdiv_q <= div_prod[46:30];
    end
    if (res_load) begin
      res_sample_q <= res_sample_d;
      res_active_q <= res_active_d;
    end
    if (out_load) begin
      out_sample_q <= res_sample_q;
      out_active_q <= res_active_q;
    end
  end

  // State memory access: read at acceptance, write back at the end.
  assign ram_re_o    = in_accept;
  assign ram_we_o    = wr_en;
  assign ram_wdata_o = wr_voice;

  assign out_valid_o = out_valid_q;
  assign sample_o    = $signed(out_sample_q);
  assign active_o    = out_active_q;

`ifndef NO_ASSERTIONS
  // The sequencer never reads the state word while a write-back is under way.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we_o && ram_re_o))
    else $error("state read and write-back in the same cycle");

  // An idle voice gives silence.
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !active_o) |-> (sample_o == '0))
    else $error("idle result carries a nonzero sample");

  // The stored tail never exceeds unity.
  a_tail_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (ram_wdata_o.tail <= TAIL_ONE))
    else $error("tail gain above 1.0 written back");

  // The second multiply stage always follows the first.
  a_mul_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL1) |=> (state_q == ST_MUL2))
    else $error("multiply stages out of order");
`endif

endmodule
`default_nettype wire

>>> design/sine_voice_with_tail_decay_unit.sv
// A sounding tick passes through READ, MUL1, MUL2 and OUT before its result shows; an idle tick goes READ, OUT.
// A new request is taken only in IDLE, after a tick leaves OUT or a note on or off writes back in READ,
// as the voice state word in its registered-read memory is read, modified and written back.
// A new transaction is taken while a finished result still waits in the output register.
// Reset (asynchronous, active low) silences the voice, clears phase, level and tail,
// and sets freq_scale to 1.0; the state memory itself needs no clearing pass.
`default_nettype none
module sine_voice_with_tail_decay_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  req_type_i,
  input  wire logic [6:0]                  note_i,
  input  wire logic [6:0]                  velocity_i,
  input  wire logic                        allow_tail_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic signed [15:0]               sample_o,
  output logic                             active_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [svd_pkg::PADDR_W-1:0] paddr,
  input  wire logic [svd_pkg::PDATA_W-1:0] pwdata,
  output logic      [svd_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);
  import svd_pkg::*;

  logic [15:0]        freq_scale;
  logic               ram_we;
  logic               ram_re;
  voice_t             ram_wdata;
  logic [VOICE_W-1:0] ram_rdata;

  // Configuration registers.
  svd_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .freq_scale_o (freq_scale)
  );

  // Voice state memory.
  svd_ram #(
    .WIDTH (VOICE_W),
    .DEPTH (VOICE_DEPTH)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (1'b0),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (1'b0),
    .rdata_o (ram_rdata)
  );

  // Sequencer and sample datapath.
  svd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .freq_scale_i (freq_scale),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .note_i       (note_i),
    .velocity_i   (velocity_i),
    .allow_tail_i (allow_tail_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_o     (sample_o),
    .active_o     (active_o),
    .ram_we_o     (ram_we),
    .ram_re_o     (ram_re),
    .ram_wdata_o  (ram_wdata),
    .ram_rdata_i  (voice_t'(ram_rdata))
  );

endmodule
`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the sine voice with tail decay unit.
`timescale 1ns / 1ps
module tb;
  import svd_pkg::*;

  localparam int unsigned SINE_BITS   = svd_pkg::SINE_ADDR_BITS;
  localparam int unsigned QW_BITS     = SINE_BITS - 2;
  localparam int unsigned ROM_SIZE    = 1 << SINE_BITS;
  localparam int unsigned SETTLE      = 10;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam logic [31:0] TAIL_UNITY  = 32'd65536;
  localparam logic [63:0] HALF_PI_Q   = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [31:0] SEMI_Q30 [12] = '{
    32'd1073741824, 32'd1137589835, 32'd1205234447, 32'd1276901417,
    32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608794974,
    32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652
  };

  typedef struct packed {
    logic signed [15:0] sample;
    logic               active;
  } voice_out_t;

  // Voice predictor and the queue of samples it has promised.
  class voice_checker;
    logic signed [15:0] sine_rom [ROM_SIZE];
    logic [31:0]        note_steps [128];
    logic [15:0]        freq_scale;
    logic [31:0]        phase;
    logic [31:0]        step;
    logic [15:0]        level;
    logic [16:0]        tail;
    voice_out_t         pending_samples [$];
    int unsigned        errors;
    int unsigned        ticks;
    int unsigned        releases;

    function new();
      int unsigned q;
      int unsigned j;
      logic [15:0] v;
      logic [63:0] numer;
      logic [63:0] denom;
      for (int unsigned i = 0; i < ROM_SIZE; i++) begin
        q = i >> QW_BITS;
        j = i & ((1 << QW_BITS) - 1);
        v = q[0] ? quarter_wave((1 << QW_BITS) - j) : quarter_wave(j);
        sine_rom[i] = q[1] ? -v : v;
      end
      denom = 64'(svd_pkg::SAMPLE_RATE) << 4;
      for (int unsigned n = 0; n < 128; n++) begin
        numer = (64'd440 * 64'(SEMI_Q30[(n + 51) % 12])) << ((n + 51) / 12 - 4);
        numer = (numer + denom / 2) / denom;
        note_steps[n] = numer[31:0];
      end
      freq_scale = 16'd4096;
      phase = '0;
      step = '0;
      level = '0;
      tail = '0;
      errors = 0;
      ticks = 0;
      releases = 0;
    endfunction

    // Sine magnitude over a quarter period by a 9th-order series in Q30.
    function logic [15:0] quarter_wave(int unsigned j);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      x  = (HALF_PI_Q * 64'(j)) >> QW_BITS;
      x2 = (x * x) >> 30;
      t  = ONE_Q30 - x2 / 72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      v  = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      return v[15:0];
    endfunction

    function void set_freq_scale(logic [15:0] value);
      freq_scale = value;
    endfunction

    function int unsigned pending_count();
      return pending_samples.size();
    endfunction

    // One tick: sample from the current state, then advance phase and tail.
    function voice_out_t predict_tick();
      voice_out_t         res;
      logic signed [15:0] sv;
      logic [31:0]        mag;
      logic [31:0]        m;
      logic [63:0]        scaled;
      logic [31:0]        next_tail;
      res = '0;
      if (step == 0) return res;
      sv  = sine_rom[phase >> (32 - SINE_BITS)];
      mag = sv[15] ? 32'(-sv) : 32'(sv);
      m   = (mag * 32'(level) + 32'd16384) >> 15;
      if (tail != 0) begin
        scaled = 64'(m) * 64'(tail) + 64'd32768;
        m = scaled[47:16];
      end
      res.sample = sv[15] ? -m[15:0] : m[15:0];
      res.active = 1'b1;
      phase = phase + step;
      if (tail != 0) begin
        next_tail = (32'(tail) * 32'd99 + 32'd50) / 32'd100;
        tail = next_tail[16:0];
        if (next_tail * 200 <= TAIL_UNITY) begin
          step = '0;
          tail = '0;
          releases++;
        end
      end
      return res;
    endfunction

    // Update the state for one accepted input transaction.
    function void log_request(logic [1:0] req, logic [6:0] key, logic [6:0] vel,
                              logic allow);
      logic [63:0] scaled;
      case (req)
        REQ_NOTE_ON: begin
          scaled = 64'(note_steps[key]) * 64'(freq_scale) + 64'd2048;
          step   = scaled[43:12];
          phase  = '0;
          level  = 16'((32'd24576 * 32'(vel) + 32'd317) / 32'd635);
          tail   = '0;
        end
        REQ_NOTE_OFF: begin
          if (allow) begin
            if (tail == 0) tail = TAIL_UNITY[16:0];
          end else begin
            step = '0;
            tail = '0;
          end
        end
        REQ_TICK: begin
          ticks++;
          pending_samples.push_back(predict_tick());
        end
        default: ;
      endcase
    endfunction

    // Compare one output transaction with the oldest predicted sample.
    function void check_sample(logic signed [15:0] sample, logic active);
      voice_out_t want;
      if (pending_samples.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display("%0t: unexpected result, actual sample %0d active %0b",
                   $time, sample, active);
        return;
      end
      want = pending_samples.pop_front();
      if (sample !== want.sample) begin
        errors++;
        if (errors <= 30)
          $display("%0t: sample mismatch, expected %0d actual %0d",
                   $time, want.sample, sample);
      end
      if (active !== want.active) begin
        errors++;
        if (errors <= 30)
          $display("%0t: active mismatch, expected %0b actual %0b",
                   $time, want.active, active);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [1:0]          req_type_i   = '0;
  logic [6:0]          note_i       = '0;
  logic [6:0]          velocity_i   = '0;
  logic                allow_tail_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic signed [15:0]  sample_o;
  logic                active_o;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [PADDR_W-1:0]  paddr        = '0;
  logic [PDATA_W-1:0]  pwdata       = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  voice_checker sb;
  int unsigned  requests = 0;
  int unsigned  results = 0;
  int unsigned  settings_used = 1;
  int unsigned  tx_calm = 0;
  int unsigned  rx_calm = 0;
  int unsigned  idle_cycles = 0;

  sine_voice_with_tail_decay_unit dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Gap lengths: mostly none or short, a few long, with calm stretches.
  function automatic int unsigned pick_gap(ref int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Field values that favor the extremes now and then.
  function automatic logic [6:0] pick_field();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 7'd0;
    if (r == 1) return 7'd127;
    return 7'($urandom_range(0, 127));
  endfunction

  // Offer one input transaction and hold it until accepted.
  task automatic send_request(input logic [1:0] req, input logic [6:0] key,
                              input logic [6:0] vel, input logic allow);
    int unsigned gap;
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    note_i       <= key;
    velocity_i   <= vel;
    allow_tail_i <= allow;
    do @(posedge clk_i); while (!in_ready_o);
    sb.log_request(req, key, vel, allow);
    requests++;
    gap = pick_gap(tx_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_ticks(input int unsigned count);
    repeat (count) send_request(REQ_TICK, 7'($urandom), 7'($urandom), 1'($urandom));
  endtask

  task automatic send_note_on(input logic [6:0] key, input logic [6:0] vel);
    send_request(REQ_NOTE_ON, key, vel, 1'($urandom));
  endtask

  task automatic send_note_off(input logic allow);
    send_request(REQ_NOTE_OFF, 7'($urandom), 7'($urandom), allow);
  endtask

  // Wait until the block is idle: no input offered, every sample returned.
  task automatic drain();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // APB write of freq_scale: setup cycle, then access cycle.
  task automatic write_freq_scale(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ADDR_FREQ_SCALE;
    pwdata  <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_freq_scale(value);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly musical phrases with random content, some noise and cut notes.
  task automatic random_phrase();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      send_note_on(pick_field(), pick_field());
      send_ticks($urandom_range(1, 30));
      if ($urandom_range(0, 1)) begin
        send_note_off(1'b1);
        send_ticks($urandom_range(1, 40));
      end
    end else if (r < 75) begin
      send_note_off(1'b0);
      send_ticks($urandom_range(1, 5));
    end else begin
      repeat ($urandom_range(1, 6))
        send_request(2'($urandom), 7'($urandom), 7'($urandom), 1'($urandom));
    end
  endtask

  // Output side: random back-pressure plus one long hold-off.
  initial begin
    int unsigned gap;
    bit          held;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = pick_gap(rx_calm);
      if (!held && results >= 150) begin
        held = 1'b1;
        gap = HOLD_CYCLES;
      end
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_sample(sample_o, active_o);
      results++;
    end
  end

  // Watchdog: too many cycles without any transaction ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("sine_voice_with_tail_decay_unit test failed");
        $finish;
      end
    end
  end

  // Stimulus: directed cases at reset pitch, then random phases per setting.
  initial begin
    int unsigned phase_end;
    logic [15:0] scale;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Idle voice: tick, tail armed with no sound, tick.
    send_ticks(1);
    send_note_off(1'b1);
    send_ticks(1);
    // Lowest note at zero velocity sounds with a zero level.
    send_note_on(7'd0, 7'd0);
    send_ticks(2);
    // Highest note at full velocity, then release.
    send_note_on(7'd127, 7'd127);
    send_ticks(4);
    send_note_off(1'b1);
    send_ticks(2);
    // A second release must not restart the running decay.
    send_note_off(1'b1);
    send_ticks(2);
    // Hard stop silences the voice at once.
    send_note_off(1'b0);
    send_ticks(1);
    // The unused request code is ignored.
    send_request(REQ_UNUSED, 7'($urandom), 7'($urandom), 1'($urandom));
    send_note_on(7'd69, 7'd100);
    send_ticks(2);
    send_note_on(7'd60, 7'd64);
    send_ticks(2);

    for (int p = 0; p < 6; p++) begin
      if (p != 0) begin
        drain();
        case (p)
          1: scale = 16'h0000;
          2: scale = 16'hFFFF;
          3: scale = 16'h0001;
          4: scale = 16'h2000;
          default: scale = 16'($urandom_range(0, 65535));
        endcase
        write_freq_scale(scale);
        settings_used++;
      end
      // One release that runs all the way down to silence.
      if (p == 4) begin
        send_note_on(pick_field(), 7'd127);
        send_note_off(1'b1);
        send_ticks(560);
      end
      phase_end = requests + 180;
      while (requests < phase_end) random_phrase();
    end

    drain();
    $display("Covered %0d requests (%0d ticks, %0d results) over %0d freq_scale settings.",
             requests, sb.ticks, results, settings_used);
    $display("Releases that decayed to silence: %0d; mismatches: %0d.",
             sb.releases, sb.errors);
    if (sb.errors == 0) begin
      $display("sine_voice_with_tail_decay_unit test passed");
    end else begin
      $display("sine_voice_with_tail_decay_unit test failed");
    end
    $finish;
  end
endmodule
